// ===== src/wsb_pkg.sv =====
// Shared types, edit codes and the offset clamp for the waveshape table editor.
`default_nettype none
package wsb_pkg;
	localparam int OFS_W = 11;
	localparam logic signed [OFS_W-1:0] OFS_MAX = 11'sd1023;
	localparam logic signed [OFS_W-1:0] OFS_MIN = -11'sd1023;
	localparam int WGT_W = 15;
	localparam int CLAMP_IN_W = 40;

	typedef enum logic [2:0] {
		FN_LOAD_WEIGHT = 3'd0,
		FN_WRITE_POINT = 3'd1,
		FN_READ_POINT  = 3'd2,
		FN_BRUSH       = 3'd3,
		FN_INTERP      = 3'd4
	} func_t;

	function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [CLAMP_IN_W-1:0] v);
		logic signed [OFS_W-1:0] r;
		if (v > CLAMP_IN_W'(OFS_MAX)) begin
			r = OFS_MAX;
		end else if (v < CLAMP_IN_W'(OFS_MIN)) begin
			r = OFS_MIN;
		end else begin
			r = v[OFS_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/wsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/waveshape_table_brush_interp.sv =====
// Top level of the waveshape offset table editor: sequencer around two RAMs.
// Usage:
//  - s_axis carries one edit command per word; m_axis returns one result
//    word (read_value, done flag) per command, in order.
//  - Commands: load weight, write point, read point, brush, interpolate.
//  - One command is worked on at a time. Brush does one table
//    read-modify-write through the offset RAM port for each on-table
//    neighbour, of up to 2*(brush_points-1) with brush_points capped at
//    MAX_BRUSH. Interpolate reads the anchor, runs the divider for the
//    slope, then writes one filled point per cycle.
//  - s_axis_tready is high while the sequencer is idle, also while a
//    result still waits on m_axis; a finished command holds in its last
//    state until the result register frees up.
//  - m_axis_tvalid stays high with stable data until m_axis_tready.
//  - Reset clears the sequencer and the result valid flag; table contents
//    are undefined until written, and no clearing pass runs.
`default_nettype none
module waveshape_table_brush_interp
	import wsb_pkg::*;
#(
	parameter int POINTS       = 256,
	parameter int WEIGHT_DEPTH = 256,
	parameter int MAX_BRUSH    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// func[2:0] point[10:3] new_value[26:11] old_value[37:27]
	// brush_points[44:38] brush_step[52:45] from_point[60:53] zero[63:61]
	input  wire logic [63:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_value[10:0] done_res[11] zero[15:12]
	output      logic [15:0] m_axis_tdata
);
	localparam int AW  = $clog2(POINTS);
	localparam int WAW = $clog2(WEIGHT_DEPTH);
	localparam int IW  = $clog2(MAX_BRUSH + 1);
	localparam int KW  = 16;
	localparam int JW  = 12;
	localparam int NUM_W = 27;  // |diff| << 16
	localparam int CNT_W = 5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_RD_WAIT, ST_B_RD, ST_B_MUL, ST_B_WR,
		ST_I_RD, ST_I_DIV, ST_I_FILL, ST_FINISH
	} state_t;

	state_t state_q;

	// latched command
	logic [2:0]               func_q;
	logic [7:0]               pnt_q;
	logic signed [15:0]       nv_q;
	logic signed [OFS_W-1:0]  ov_q;
	logic [6:0]               bp_q;
	logic [7:0]               bs_q;
	logic [7:0]               fp_q;

	// result
	logic signed [OFS_W-1:0]  rd_q;
	logic                     done_q;
	logic                     out_valid_q;
	logic signed [OFS_W-1:0]  out_rd_q;
	logic                     out_done_q;

	// brush walk
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            bpe_q;
	logic [KW-1:0]            k_q;
	logic                     side_q;
	logic                     kval_q;
	logic signed [12:0]       diff_q;
	logic signed [28:0]       prod_s2;
	logic signed [OFS_W-1:0]  tab_s2;
	logic [AW-1:0]            j_q;

	// interpolate
	logic [AW-1:0]            lo_q;
	logic [AW-1:0]            n_q;
	logic [AW-1:0]            m_q;
	logic signed [OFS_W-1:0]  base_q;
	logic                     neg_q;
	logic [NUM_W-1:0]         quo_q;
	logic [AW:0]              rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [NUM_W:0]    slope_q;
	logic signed [NUM_W+AW:0] acc_q;

	// RAM ports
	logic                     t_we, t_re, w_we, w_re;
	logic [AW-1:0]            t_waddr, t_raddr;
	logic signed [OFS_W-1:0]  t_wdata, t_rdata;
	logic [WAW-1:0]           w_waddr, w_raddr;
	logic [WGT_W-1:0]         w_wdata, w_rdata;

	wsb_ram #(.WIDTH(OFS_W), .DEPTH(POINTS)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rdata)
	);

	wsb_ram #(.WIDTH(WGT_W), .DEPTH(WEIGHT_DEPTH)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);

	wire in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_done_q, out_rd_q};

	// decode of the latched command
	logic signed [OFS_W-1:0]  cur;
	logic                     pnt_ok, wpt_ok, fp_ok;
	logic [AW-1:0]            pnt_a, fp_a, lo_a, hi_a;
	logic [IW-1:0]            bpe;
	assign cur    = clamp_ofs(CLAMP_IN_W'(nv_q));
	assign pnt_ok = 32'(pnt_q) < POINTS;
	assign wpt_ok = 32'(pnt_q) < WEIGHT_DEPTH;
	assign fp_ok  = 32'(fp_q) < POINTS;
	assign pnt_a  = AW'(pnt_q);
	assign fp_a   = AW'(fp_q);
	assign lo_a   = (fp_q < pnt_q) ? fp_a : pnt_a;
	assign hi_a   = (fp_q < pnt_q) ? pnt_a : fp_a;
	assign bpe    = (32'(bp_q) > MAX_BRUSH) ? IW'(MAX_BRUSH) : IW'(bp_q);

	// current brush neighbour
	logic signed [JW-1:0] j_s;
	logic                 j_ok;
	logic                 last_nb;
	assign j_s  = side_q ? (JW'(pnt_q) - JW'(i_q)) : (JW'(pnt_q) + JW'(i_q));
	assign j_ok = (j_s >= 0) && (32'(j_s) < POINTS);
	assign last_nb = side_q && ((i_q + 1'b1) == bpe_q);

	// neighbour update: delta = (diff*w + 16384) / 32768, toward zero
	logic signed [29:0] rnd;
	logic signed [29:0] delta;
	logic signed [OFS_W-1:0] nb_new;
	assign rnd    = 30'(prod_s2) + 30'sd16384;
	assign delta  = (rnd + (rnd[29] ? 30'sd32767 : 30'sd0)) >>> 15;
	assign nb_new = clamp_ofs(CLAMP_IN_W'(tab_s2) - CLAMP_IN_W'(delta));

	// divider step and fill value
	logic [AW+1:0] rem_sh;
	logic          q_bit;
	logic signed [OFS_W-1:0] fill_v;
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign q_bit  = rem_sh >= (AW+2)'(n_q);
	assign fill_v = clamp_ofs(CLAMP_IN_W'(acc_q >>> 16) + CLAMP_IN_W'(base_q));

	always_comb begin
		t_we = 1'b0; t_waddr = pnt_a; t_wdata = cur;
		t_re = 1'b0; t_raddr = pnt_a;
		w_we = 1'b0; w_waddr = WAW'(pnt_q); w_wdata = nv_q[WGT_W-1:0];
		w_re = 1'b0; w_raddr = WAW'(k_q);
		case (state_q)
			ST_DISPATCH: begin
				case (func_q)
					FN_LOAD_WEIGHT: w_we = wpt_ok;
					FN_WRITE_POINT: t_we = pnt_ok;
					FN_READ_POINT:  t_re = pnt_ok;
					FN_BRUSH:       t_we = pnt_ok && (bpe != '0);
					FN_INTERP: begin
						// anchor read only when it is a different entry
						t_we    = pnt_ok;
						t_re    = pnt_ok && fp_ok && (fp_q != pnt_q);
						t_raddr = fp_a;
					end
					default: ;
				endcase
			end
			ST_B_RD: begin
				t_re    = j_ok;
				t_raddr = AW'(j_s);
				w_re    = j_ok;
			end
			ST_B_WR: begin
				t_we    = 1'b1;
				t_waddr = j_q;
				t_wdata = nb_new;
			end
			ST_I_FILL: begin
				t_we    = 1'b1;
				t_waddr = lo_q + m_q;
				t_wdata = fill_v;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// the finish state handles its own handoff
			if (out_valid_q && m_axis_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					rd_q <= '0;
					case (func_q)
						FN_LOAD_WEIGHT: begin
							done_q  <= wpt_ok;
							state_q <= ST_FINISH;
						end
						FN_WRITE_POINT: begin
							done_q  <= pnt_ok;
							state_q <= ST_FINISH;
						end
						FN_READ_POINT: begin
							done_q  <= 1'b0;
							state_q <= pnt_ok ? ST_RD_WAIT : ST_FINISH;
						end
						FN_BRUSH: begin
							done_q <= pnt_ok;
							i_q    <= IW'(1);
							k_q    <= KW'(bs_q);
							side_q <= 1'b0;
							bpe_q  <= bpe;
							diff_q <= 13'(ov_q) - 13'(cur);
							state_q <= (pnt_ok && bpe > IW'(1)) ? ST_B_RD : ST_FINISH;
						end
						FN_INTERP: begin
							done_q <= pnt_ok;
							lo_q   <= lo_a;
							n_q    <= hi_a - lo_a;
							state_q <= (pnt_ok && fp_ok && (hi_a - lo_a) > AW'(1))
							           ? ST_I_RD : ST_FINISH;
						end
						default: begin
							done_q  <= 1'b0;
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_RD_WAIT: begin
					rd_q    <= t_rdata;
					done_q  <= 1'b1;
					state_q <= ST_FINISH;
				end
				ST_B_RD: begin
					kval_q <= 32'(k_q) < WEIGHT_DEPTH;
					j_q    <= AW'(j_s);
					if (j_ok) begin
						state_q <= ST_B_MUL;
					end else begin
						side_q <= !side_q;
						if (side_q) begin
							i_q <= i_q + 1'b1;
							k_q <= k_q + KW'(bs_q);
						end
						if (last_nb) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_B_MUL: begin
					prod_s2 <= 29'(diff_q) * $signed({1'b0, kval_q ? w_rdata : '0});
					tab_s2  <= t_rdata;
					state_q <= ST_B_WR;
				end
				ST_B_WR: begin
					side_q <= !side_q;
					if (side_q) begin
						i_q <= i_q + 1'b1;
						k_q <= k_q + KW'(bs_q);
					end
					state_q <= last_nb ? ST_FINISH : ST_B_RD;
				end
				ST_I_RD: begin
					logic signed [12:0] d;
					if (fp_q < pnt_q) begin
						base_q <= t_rdata;
						d = 13'(cur) - 13'(t_rdata);
					end else begin
						base_q <= cur;
						d = 13'(t_rdata) - 13'(cur);
					end
					neg_q   <= d[12];
					quo_q   <= {11'(d[12] ? -d : d), 16'd0};
					rem_q   <= '0;
					cnt_q   <= CNT_W'(NUM_W);
					state_q <= ST_I_DIV;
				end
				ST_I_DIV: begin
					if (cnt_q == '0) begin
						slope_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
						acc_q   <= neg_q ? -(NUM_W+AW+1)'($signed({1'b0, quo_q}))
						                 : (NUM_W+AW+1)'($signed({1'b0, quo_q}));
						m_q     <= AW'(1);
						state_q <= ST_I_FILL;
					end else begin
						rem_q <= q_bit ? (AW+1)'(rem_sh - (AW+2)'(n_q)) : rem_sh[AW:0];
						quo_q <= {quo_q[NUM_W-2:0], q_bit};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_I_FILL: begin
					acc_q <= acc_q + (NUM_W+AW+1)'(slope_q);
					m_q   <= m_q + 1'b1;
					if ((m_q + 1'b1) == n_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= rd_q;
						out_done_q  <= done_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= s_axis_tdata[2:0];
			pnt_q  <= s_axis_tdata[10:3];
			nv_q   <= s_axis_tdata[26:11];
			ov_q   <= s_axis_tdata[37:27];
			bp_q   <= s_axis_tdata[44:38];
			bs_q   <= s_axis_tdata[52:45];
			fp_q   <= s_axis_tdata[60:53];
		end
	end

	// same-entry read and write never meet in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		t_we && t_re |-> t_waddr != t_raddr) else $error("table read/write clash");
	// fill index stays strictly inside the span
	a_fill_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_I_FILL |-> (m_q < n_q) && (m_q != '0)) else $error("fill out of span");
	// busy right after taking a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready) else $error("accepted while busy");
	// a result is only loaded from the finish state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH) else $error("stray result");
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the waveshape offset table editor: stream driver, result checker, predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import wsb_pkg::*;

	localparam int N_PTS   = 256;
	localparam int N_WGT   = 256;
	localparam int BRUSH_MAX = 64;
	localparam int N_RAND  = 1200;
	localparam int LIMIT_LO = -1023;
	localparam int LIMIT_HI = 1023;
	// func codes with no command behind them
	localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [2:0]         func;
		logic [7:0]         pnt;
		logic signed [15:0] nv;
		logic signed [10:0] ov;
		logic [6:0]         bp;
		logic [7:0]         bs;
		logic [7:0]         fp;
		int                 idle_pct;   // sender idle chance before this word
		int                 stall_pct;  // receiver stall chance while it runs
		bit                 drain;      // hold until every result is back
	} edit_t;

	typedef struct {
		logic signed [10:0] rd;
		logic               ok;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	edit_t   pending_edits[$];
	answer_t expected_answers[$];
	edit_t   shown_edit;
	int      stall_pct;
	int      fail_count;

	// shadow copies of the two tables
	int ofs_tbl[N_PTS];
	int wgt_tbl[N_WGT];

	waveshape_table_brush_interp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int clamp_pt(input longint v);
		if (v > LIMIT_HI) return LIMIT_HI;
		if (v < LIMIT_LO) return LIMIT_LO;
		return int'(v);
	endfunction

	// brush pull on one neighbour; off-table neighbours are skipped
	function automatic void pull_point(input int j, input int diff, input int w);
		int delta;
		if (j < 0 || j >= N_PTS) return;
		delta = (diff * w + 16384) / 32768;   // truncates toward zero
		ofs_tbl[j] = clamp_pt(ofs_tbl[j] - delta);
	endfunction

	// applies one edit to the shadow tables and returns its result word
	function automatic answer_t apply_edit(input edit_t e);
		answer_t a;
		int cur, nbp, k, w, lo, hi, n, base;
		longint slope, v, q;
		a.rd = '0;
		a.ok = 1'b1;
		cur = clamp_pt(longint'(e.nv));
		case (e.func)
			FN_LOAD_WEIGHT: wgt_tbl[e.pnt] = int'(e.nv[14:0]);
			FN_WRITE_POINT: ofs_tbl[e.pnt] = cur;
			FN_READ_POINT:  a.rd = ofs_tbl[e.pnt][10:0];
			FN_BRUSH: begin
				nbp = (e.bp > BRUSH_MAX) ? BRUSH_MAX : int'(e.bp);
				for (int i = 0; i < nbp; i++) begin
					if (i == 0) begin
						ofs_tbl[e.pnt] = cur;
					end else begin
						k = i * e.bs;
						w = (k < N_WGT) ? wgt_tbl[k] : 0;
						pull_point(int'(e.pnt) + i, int'(e.ov) - cur, w);
						pull_point(int'(e.pnt) - i, int'(e.ov) - cur, w);
					end
				end
			end
			FN_INTERP: begin
				ofs_tbl[e.pnt] = cur;
				lo = (e.fp < e.pnt) ? e.fp : e.pnt;
				hi = (e.fp < e.pnt) ? e.pnt : e.fp;
				n = hi - lo;
				if (n > 1) begin
					base = ofs_tbl[lo];
					slope = (longint'(ofs_tbl[hi] - base) * 65536) / n;
					for (int m = 1; m < n; m++) begin
						v = slope * m;
						q = (v >= 0) ? v / 65536 : -((-v + 65535) / 65536);
						ofs_tbl[lo + m] = clamp_pt(q + base);
					end
				end
			end
			default: a.ok = 1'b0;
		endcase
		return a;
	endfunction

	function automatic edit_t make_edit(input logic [2:0] func, input int pnt, input int nv,
			input int ov, input int bp, input int bs, input int fp);
		edit_t e;
		e.func = func;
		e.pnt = pnt[7:0];
		e.nv = nv[15:0];
		e.ov = ov[10:0];
		e.bp = bp[6:0];
		e.bs = bs[7:0];
		e.fp = fp[7:0];
		e.idle_pct = 0;
		e.stall_pct = 0;
		e.drain = 1'b0;
		return e;
	endfunction

	function automatic edit_t random_edit();
		int r, nv, bp, bs;
		logic [2:0] func;
		r = $urandom_range(0, 99);
		if (r < 8)       func = FN_LOAD_WEIGHT;
		else if (r < 25) func = FN_WRITE_POINT;
		else if (r < 45) func = FN_READ_POINT;
		else if (r < 75) func = FN_BRUSH;
		else if (r < 95) func = FN_INTERP;
		else             func = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
		nv = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2046) - 1023 : int'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70)      bp = $urandom_range(0, 12);
		else if (r < 95) bp = $urandom_range(13, 64);
		else             bp = $urandom_range(65, 127);
		bs = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 255);
		return make_edit(func, $urandom_range(0, 255), nv, $urandom_range(0, 2046) - 1023,
			bp, bs, $urandom_range(0, 255));
	endfunction

	// stimulus: fill both tables first so nothing unwritten is ever read,
	// then directed corners, then random edits over four idling phases
	initial begin
		edit_t e;
		for (int i = 0; i < N_WGT; i++) begin
			pending_edits.push_back(make_edit(FN_LOAD_WEIGHT, i,
				(i % 37 == 0) ? 32767 : $urandom_range(0, 32767), 0, 0, 0, 0));
		end
		for (int i = 0; i < N_PTS; i++) begin
			pending_edits.push_back(make_edit(FN_WRITE_POINT, i,
				$urandom_range(0, 2046) - 1023, 0, 0, 0, 0));
		end
		// directed corners
		pending_edits.push_back(make_edit(FN_LOAD_WEIGHT, 3, -1, 0, 0, 0, 0));  // low 15 bits kept
		pending_edits.push_back(make_edit(FN_LOAD_WEIGHT, 255, 32767, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_WRITE_POINT, 10, 32767, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_WRITE_POINT, 11, -32768, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_WRITE_POINT, 12, -1023, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_READ_POINT, 10, 0, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_READ_POINT, 11, 0, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_READ_POINT, 255, 0, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_BRUSH, 0, 1023, -1023, 64, 1, 0));   // low edge
		pending_edits.push_back(make_edit(FN_BRUSH, 255, -1023, 1023, 127, 255, 0)); // over max
		pending_edits.push_back(make_edit(FN_BRUSH, 100, 500, 0, 0, 3, 0));     // touches nothing
		pending_edits.push_back(make_edit(FN_BRUSH, 128, 32767, -1023, 64, 0, 0));
		pending_edits.push_back(make_edit(FN_BRUSH, 60, -32768, 1023, 40, 7, 0)); // step past table
		pending_edits.push_back(make_edit(FN_READ_POINT, 61, 0, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_INTERP, 255, 1023, 0, 0, 0, 0));   // full span
		pending_edits.push_back(make_edit(FN_INTERP, 0, -1023, 0, 0, 0, 255));  // reversed
		pending_edits.push_back(make_edit(FN_INTERP, 40, 300, 0, 0, 0, 40));    // same point
		pending_edits.push_back(make_edit(FN_INTERP, 41, -300, 0, 0, 0, 40));   // adjacent
		pending_edits.push_back(make_edit(FN_INTERP, 90, -32768, 0, 0, 0, 87));
		pending_edits.push_back(make_edit(FN_READ_POINT, 89, 0, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_SPARE_FIRST, 5, 100, 0, 0, 0, 0));
		pending_edits.push_back(make_edit(FN_SPARE_LAST, 255, -1, -1, 127, 255, 255));
		for (int r = 0; r < N_RAND; r++) begin
			e = random_edit();
			case ((r * 4) / N_RAND)
				0: begin e.idle_pct = 0;  e.stall_pct = 0;  end
				1: begin e.idle_pct = 64; e.stall_pct = 0;  end
				2: begin e.idle_pct = 0;  e.stall_pct = 64; end
				default: begin e.idle_pct = 10; e.stall_pct = 10; end
			endcase
			e.drain = (r % 300 == 150);
			pending_edits.push_back(e);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		stall_pct = 0;
		fail_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: new word or idle at the falling edge once the last one was taken
	logic s_took;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_took) begin
				if (pending_edits.size() > 0
						&& !(pending_edits[0].drain && expected_answers.size() > 0)
						&& $urandom_range(0, 99) >= pending_edits[0].idle_pct) begin
					shown_edit = pending_edits.pop_front();
					stall_pct = shown_edit.stall_pct;
					s_axis_tdata <= {3'b000, shown_edit.fp, shown_edit.bs, shown_edit.bp,
						shown_edit.ov, shown_edit.nv, shown_edit.pnt, shown_edit.func};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor: check result words, predict accepted commands
	always @(posedge clk) begin
		answer_t a;
		s_took = s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_answers.size() == 0) begin
				$error("result word with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				a = expected_answers.pop_front();
				if (m_axis_tdata[10:0] !== a.rd) begin
					$error("read_value: expected %0d, got %0d", a.rd,
						$signed(m_axis_tdata[10:0]));
					fail_count++;
				end
				if (m_axis_tdata[11] !== a.ok) begin
					$error("done_res: expected %0d, got %0d", a.ok, m_axis_tdata[11]);
					fail_count++;
				end
			end
		end
		if (s_took) expected_answers.push_back(apply_edit(shown_edit));
	end

	initial begin
		wait (arst_n);
		wait (pending_edits.size() == 0 && !s_axis_tvalid && expected_answers.size() == 0);
		repeat (500) @(posedge clk);
		if (fail_count == 0 && expected_answers.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
